// ===== src/bn254_alu_pkg.sv =====
package bn254_alu_pkg;

  localparam int LIMB_COUNT = 8;
  localparam int LIMB_WIDTH = 32;
  localparam int LIMB_IDX_W = $clog2(LIMB_COUNT);
  localparam int FIELD_W    = LIMB_COUNT * LIMB_WIDTH;
  localparam int EXP_IDX_W  = $clog2(FIELD_W);

  localparam logic [FIELD_W-1:0] FIELD_Q =
    256'h30644e72e131a029b85045b68181585d97816a916871ca8d3c208c16d87cfd47;
  localparam logic [FIELD_W-1:0] MONT_R1 =
    256'h0e0a77c19a07df2f666ea36f7879462c0a78eb28f5c70b3dd35d438dc58f0d9d;
  localparam logic [FIELD_W-1:0] MONT_R2 =
    256'h06d89f71cab8351f47ab1eff0a417ff6b5e71911d44501fbf32cfc5b538afa89;
  localparam logic [FIELD_W-1:0] EXP_Q2 =
    256'h30644e72e131a029b85045b68181585d97816a916871ca8d3c208c16d87cfd45;
  localparam logic [LIMB_WIDTH-1:0] NEG_QINV = 32'he4866389;

  typedef logic [LIMB_WIDTH-1:0] limb_t;
  typedef logic [LIMB_IDX_W-1:0] lidx_t;

  typedef enum logic [2:0] {
    FN_MUL    = 3'd0,
    FN_ADD    = 3'd1,
    FN_SUB    = 3'd2,
    FN_NEG    = 3'd3,
    FN_INV    = 3'd4,
    FN_TO_MONT = 3'd5,
    FN_FROM_MONT = 3'd6,
    FN_NONE   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    SRC_A, SRC_B, SRC_PB, SRC_PR, SRC_R2, SRC_ONE
  } src_t;

  typedef enum logic [1:0] {
    DST_OUT, DST_PB, DST_PR
  } dst_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL1T, ST_MQ, ST_MUL2, ST_MUL2T, ST_FSUB,
    ST_ADD, ST_SUB, ST_ADDQ, ST_NEG, ST_COPY, ST_INIT, ST_INVBIT, ST_OUT
  } state_t;

  function automatic limb_t limb_of(input logic [FIELD_W-1:0] v, input lidx_t j);
    limb_of = v[j*LIMB_WIDTH +: LIMB_WIDTH];
  endfunction

endpackage

// ===== src/bn254_base_field_alu.sv =====
// Arithmetic modulo the BN254 base prime on 256-bit values fed as eight 32-bit
// limbs, least significant first, one limb of a and b per input beat. The beat
// with limb_index 7 starts the selected operation; the block then drops ready
// until all eight result beats have left. All arithmetic runs on one 32x32
// multiply-accumulate and one 32-bit adder, one limb per cycle. Add is an add
// pass and a conditional subtraction of the modulus, subtract a subtract pass
// and a conditional add of it, negate one pass; a Montgomery product (multiply,
// conversion into or out of Montgomery form) runs the multiply-accumulate word
// loop and a final subtraction; the inverse runs up to 512 such products plus
// copies. Results stream out at one beat per cycle when out_ready is high.
module bn254_base_field_alu (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_func,
  input  bn254_alu_pkg::lidx_t         in_limb_index,
  input  bn254_alu_pkg::limb_t         in_a_limb,
  input  bn254_alu_pkg::limb_t         in_b_limb,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bn254_alu_pkg::lidx_t         out_index,
  output bn254_alu_pkg::limb_t         out_limb,
  output logic                         out_last
);
  import bn254_alu_pkg::*;

  state_t state_r, state_nxt;

  limb_t a_st_r [LIMB_COUNT];
  limb_t b_st_r [LIMB_COUNT];
  limb_t acc_r  [LIMB_COUNT+1];
  limb_t res_r  [LIMB_COUNT];
  limb_t pb_r   [LIMB_COUNT];
  limb_t pr_r   [LIMB_COUNT];

  lidx_t i_r, j_r, k_r;
  limb_t c_r, m_r;
  logic top_r, flag_r, use_acc_r, zero_r, from_pr_r, did_mul_r;
  logic [EXP_IDX_W-1:0] e_r;
  src_t xsrc_r, ysrc_r;
  dst_t dst_r;

  limb_t xw, yw, mul_a, mul_b, addend, cin, as_p, as_q;
  logic as_ci;
  logic [2*LIMB_WIDTH-1:0] mac;
  logic [LIMB_WIDTH:0] as_s;
  logic in_acc, out_acc, start, last_j, exp_bit;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign start   = in_acc && (in_limb_index == lidx_t'(LIMB_COUNT-1))
                   && (in_func != FN_NONE);
  assign last_j  = (j_r == lidx_t'(LIMB_COUNT-1));
  assign exp_bit = EXP_Q2[e_r];

  // operand limbs of the running product
  always_comb begin
    case (xsrc_r)
      SRC_PB:  xw = pb_r[j_r];
      SRC_PR:  xw = pr_r[j_r];
      default: xw = a_st_r[j_r];
    endcase
    case (ysrc_r)
      SRC_B:   yw = b_st_r[i_r];
      SRC_PB:  yw = pb_r[i_r];
      SRC_R2:  yw = limb_of(MONT_R2, i_r);
      SRC_ONE: yw = (i_r == '0) ? limb_t'(1) : '0;
      default: yw = a_st_r[i_r];
    endcase
  end

  // shared multiply-accumulate
  always_comb begin
    mul_a = '0; mul_b = '0; addend = '0; cin = c_r;
    case (state_r)
      ST_MUL1: begin
        mul_a = xw; mul_b = yw;
        addend = (i_r == '0) ? '0 : acc_r[{1'b0, j_r}];
      end
      ST_MUL1T: addend = (i_r == '0) ? '0 : acc_r[LIMB_COUNT];
      ST_MQ: begin
        mul_a = acc_r[0]; mul_b = NEG_QINV; cin = '0;
      end
      ST_MUL2: begin
        mul_a = m_r; mul_b = limb_of(FIELD_Q, j_r); addend = acc_r[{1'b0, j_r}];
      end
      ST_MUL2T: addend = acc_r[LIMB_COUNT];
      default: ;
    endcase
    mac = {{LIMB_WIDTH{1'b0}}, addend} + mul_a * mul_b + {{LIMB_WIDTH{1'b0}}, cin};
  end

  // shared adder, subtraction as add of the complement with carry as not-borrow
  always_comb begin
    as_p = '0; as_q = '0;
    case (state_r)
      ST_FSUB: begin as_p = acc_r[{1'b0, j_r}]; as_q = ~limb_of(FIELD_Q, j_r); end
      ST_ADD:  begin as_p = a_st_r[j_r]; as_q = b_st_r[j_r]; end
      ST_SUB:  begin as_p = a_st_r[j_r]; as_q = ~b_st_r[j_r]; end
      ST_ADDQ: begin
        as_p = acc_r[{1'b0, j_r}];
        as_q = flag_r ? limb_of(FIELD_Q, j_r) : '0;
      end
      ST_NEG:  begin as_p = limb_of(FIELD_Q, j_r); as_q = ~a_st_r[j_r]; end
      default: ;
    endcase
    as_ci = c_r[0];
    as_s  = {1'b0, as_p} + {1'b0, as_q} + {{LIMB_WIDTH{1'b0}}, as_ci};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) begin
        case (in_func)
          FN_ADD:  state_nxt = ST_ADD;
          FN_SUB:  state_nxt = ST_SUB;
          FN_NEG:  state_nxt = ST_NEG;
          FN_INV:  state_nxt = ST_INIT;
          default: state_nxt = ST_MUL1;
        endcase
      end
      ST_MUL1:  if (last_j) state_nxt = ST_MUL1T;
      ST_MUL1T: state_nxt = ST_MQ;
      ST_MQ:    state_nxt = ST_MUL2;
      ST_MUL2:  if (last_j) state_nxt = ST_MUL2T;
      ST_MUL2T: state_nxt = (i_r == lidx_t'(LIMB_COUNT-1)) ? ST_FSUB : ST_MUL1;
      ST_FSUB:  if (last_j) state_nxt = (dst_r == DST_OUT) ? ST_OUT : ST_COPY;
      ST_ADD:   if (last_j) state_nxt = ST_FSUB;
      ST_SUB:   if (last_j) state_nxt = ST_ADDQ;
      ST_ADDQ:  if (last_j) state_nxt = ST_OUT;
      ST_NEG:   if (last_j) state_nxt = ST_OUT;
      ST_INIT:  if (last_j) state_nxt = ST_INVBIT;
      ST_INVBIT: state_nxt = ST_MUL1;
      ST_COPY: if (last_j) begin
        if (dst_r == DST_PB && e_r == '1) state_nxt = ST_OUT;
        else                              state_nxt = ST_INVBIT;
      end
      ST_OUT: if (out_acc && k_r == lidx_t'(LIMB_COUNT-1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    out_index = k_r;
    out_last  = (k_r == lidx_t'(LIMB_COUNT-1));
    if (zero_r)         out_limb = '0;
    else if (from_pr_r) out_limb = pr_r[k_r];
    else if (use_acc_r) out_limb = acc_r[{1'b0, k_r}];
    else                out_limb = res_r[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      for (int n = 0; n <= LIMB_COUNT; n++) acc_r[n] <= '0;
      i_r <= '0; j_r <= '0; k_r <= '0; c_r <= '0; m_r <= '0;
      top_r <= 1'b0; flag_r <= 1'b0; use_acc_r <= 1'b0; zero_r <= 1'b0;
      from_pr_r <= 1'b0; did_mul_r <= 1'b0; e_r <= '0;
      xsrc_r <= SRC_A; ysrc_r <= SRC_B; dst_r <= DST_OUT;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            a_st_r[in_limb_index] <= in_a_limb;
            b_st_r[in_limb_index] <= in_b_limb;
          end
          i_r <= '0; j_r <= '0; k_r <= '0;
          zero_r <= 1'b0; from_pr_r <= 1'b0; use_acc_r <= 1'b0;
          e_r <= '0; did_mul_r <= 1'b0; flag_r <= 1'b0;
          xsrc_r <= SRC_A; dst_r <= DST_OUT;
          case (in_func)
            FN_TO_MONT:   ysrc_r <= SRC_R2;
            FN_FROM_MONT: ysrc_r <= SRC_ONE;
            default:      ysrc_r <= SRC_B;
          endcase
          c_r <= (in_func == FN_SUB || in_func == FN_NEG) ? limb_t'(1) : '0;
        end
        ST_MUL1: begin
          acc_r[{1'b0, j_r}] <= mac[LIMB_WIDTH-1:0];
          c_r <= mac[2*LIMB_WIDTH-1:LIMB_WIDTH];
          j_r <= j_r + 1'b1;
        end
        ST_MUL1T: begin
          acc_r[LIMB_COUNT] <= mac[LIMB_WIDTH-1:0];
          top_r <= mac[LIMB_WIDTH];
          c_r <= '0;
        end
        ST_MQ: m_r <= mac[LIMB_WIDTH-1:0];
        ST_MUL2: begin
          if (j_r != '0) acc_r[{1'b0, j_r - 1'b1}] <= mac[LIMB_WIDTH-1:0];
          c_r <= mac[2*LIMB_WIDTH-1:LIMB_WIDTH];
          j_r <= j_r + 1'b1;
        end
        ST_MUL2T: begin
          acc_r[LIMB_COUNT-1] <= mac[LIMB_WIDTH-1:0];
          acc_r[LIMB_COUNT]   <= limb_t'(top_r) + limb_t'(mac[LIMB_WIDTH]);
          i_r <= i_r + 1'b1;
          // the final subtraction starts with no borrow
          c_r <= (i_r == lidx_t'(LIMB_COUNT-1)) ? limb_t'(1) : '0;
        end
        ST_FSUB: begin
          res_r[j_r] <= as_s[LIMB_WIDTH-1:0];
          c_r <= limb_t'(as_s[LIMB_WIDTH]);
          j_r <= j_r + 1'b1;
          if (last_j) use_acc_r <= !as_s[LIMB_WIDTH] && (acc_r[LIMB_COUNT] == '0);
        end
        ST_ADD: begin
          acc_r[{1'b0, j_r}] <= as_s[LIMB_WIDTH-1:0];
          c_r <= last_j ? limb_t'(1) : limb_t'(as_s[LIMB_WIDTH]);
          j_r <= j_r + 1'b1;
          if (last_j) acc_r[LIMB_COUNT] <= limb_t'(as_s[LIMB_WIDTH]);
        end
        ST_SUB: begin
          acc_r[{1'b0, j_r}] <= as_s[LIMB_WIDTH-1:0];
          c_r <= last_j ? '0 : limb_t'(as_s[LIMB_WIDTH]);
          j_r <= j_r + 1'b1;
          if (last_j) flag_r <= !as_s[LIMB_WIDTH];
        end
        ST_ADDQ: begin
          res_r[j_r] <= as_s[LIMB_WIDTH-1:0];
          c_r <= limb_t'(as_s[LIMB_WIDTH]);
          j_r <= j_r + 1'b1;
        end
        ST_NEG: begin
          res_r[j_r] <= as_s[LIMB_WIDTH-1:0];
          c_r <= limb_t'(as_s[LIMB_WIDTH]);
          j_r <= j_r + 1'b1;
          // flag tracks a nonzero limb of a
          if (a_st_r[j_r] != '0) flag_r <= 1'b1;
          if (last_j) zero_r <= !(flag_r || a_st_r[j_r] != '0);
        end
        ST_INIT: begin
          pb_r[j_r] <= a_st_r[j_r];
          pr_r[j_r] <= limb_of(MONT_R1, j_r);
          j_r <= j_r + 1'b1;
        end
        ST_INVBIT: begin
          i_r <= '0; j_r <= '0; c_r <= '0;
          ysrc_r <= SRC_PB;
          if (exp_bit && !did_mul_r) begin
            xsrc_r <= SRC_PR; dst_r <= DST_PR;
          end else begin
            xsrc_r <= SRC_PB; dst_r <= DST_PB;
          end
        end
        ST_COPY: begin
          if (dst_r == DST_PR) pr_r[j_r] <= use_acc_r ? acc_r[{1'b0, j_r}] : res_r[j_r];
          else                 pb_r[j_r] <= use_acc_r ? acc_r[{1'b0, j_r}] : res_r[j_r];
          j_r <= j_r + 1'b1;
          if (last_j) begin
            if (dst_r == DST_PR) begin
              did_mul_r <= 1'b1;
            end else begin
              did_mul_r <= 1'b0;
              e_r <= e_r + 1'b1;
              if (e_r == '1) from_pr_r <= 1'b1;
            end
          end
        end
        ST_OUT: if (out_acc) k_r <= k_r + 1'b1;
        default: ;
      endcase
    end
  end

endmodule
